FILE: sv/tccw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared constants, codes and controller/datapath interface types for the
// text console character writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

    // grid geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int ADDR_W  = $clog2(CELLS);

    // field widths
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int TAB_W  = 4;

    localparam logic [TAB_W-1:0]  TAB_RESET = 4'd8;

    // character codes
    localparam logic [CHAR_W-1:0] CH_BACK    = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

    // request modes
    typedef enum logic [1:0] {
        MODE_PRINT = 2'd0,
        MODE_READ  = 2'd1,
        MODE_WRITE = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    // sweep address operations
    typedef enum logic [2:0] {
        SW_HOLD,
        SW_ZERO,
        SW_SCROLL,
        SW_BLANK,
        SW_INC
    } sweep_op_t;

    // write address sources
    typedef enum logic [1:0] {
        WA_SWEEP,
        WA_CURSOR,
        WA_PREV,
        WA_INPUT
    } waddr_sel_t;

    // write data sources
    typedef enum logic [1:0] {
        WD_SPACE,
        WD_CHAR,
        WD_COPY
    } wdata_sel_t;

    // read address sources
    typedef enum logic {
        RA_SWEEP,
        RA_INPUT
    } raddr_sel_t;

    // cursor operations
    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_HOME,
        CUR_NEXT_ROW,
        CUR_COL0,
        CUR_INC,
        CUR_DEC
    } cur_op_t;

    // tab counter operations
    typedef enum logic [1:0] {
        TAB_HOLD,
        TAB_LOAD,
        TAB_DEC
    } tab_op_t;

    // controller to datapath
    typedef struct packed {
        logic       in_ready;
        sweep_op_t  sweep_op;
        logic       mem_we;
        waddr_sel_t waddr_sel;
        wdata_sel_t wdata_sel;
        raddr_sel_t raddr_sel;
        cur_op_t    cur_op;
        tab_op_t    tab_op;
        logic       set_printed;
        logic       cell_cap;
        logic       out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        mode_t mode;
        logic  is_tab;
        logic  is_bs;
        logic  is_nl;
        logic  at_wrap;
        logic  at_bottom;
        logic  col_zero;
        logic  tab_zero;
        logic  addr_ok;
        logic  copy_end;
        logic  sweep_end;
        logic  out_busy;
    } status_t;

    // controller states
    typedef enum logic [11:0] {
        S_INIT_CLR = 12'b0000_0000_0001,
        S_IDLE     = 12'b0000_0000_0010,
        S_DECODE   = 12'b0000_0000_0100,
        S_PCHAR    = 12'b0000_0000_1000,
        S_TAB_CHK  = 12'b0000_0001_0000,
        S_TAB_WR   = 12'b0000_0010_0000,
        S_SC_RD    = 12'b0000_0100_0000,
        S_SC_WR    = 12'b0000_1000_0000,
        S_SC_BL    = 12'b0001_0000_0000,
        S_RD_CAP   = 12'b0010_0000_0000,
        S_CLR      = 12'b0100_0000_0000,
        S_FINISH   = 12'b1000_0000_0000
    } state_t;

endpackage

FILE: sv/text_console_char_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_writer
// 80x25 text console with cursor, status row, tab expansion and scrolling.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_ready (mode, char_code, column, row); each one
// gives exactly one result on out_valid/out_ready (cell_char, cursor_row,
// cursor_col, printed). tab_width is written through cfg_wr_en/cfg_wr_data;
// the user writes it only while the console is idle; the block does not enforce this.
// One request is handled at a time by the sequencer over the one-write,
// one-read grid memory. Every request passes S_DECODE and ends in S_FINISH;
// a plain character, backspace or newline goes through S_PCHAR, a cell read
// through S_RD_CAP, and a tab loops S_TAB_CHK and S_TAB_WR once per space.
// A scroll (wrap or newline at the bottom row) copies rows 2 to ROWS-1 up a
// row, a read then a write per cell, then blanks the bottom row. Clear screen
// sweeps every cell once. After reset a blanking pass over every cell runs
// before in_ready rises; the cursor starts at row 1, column 0, tab width 8.
// A result waits in the output register while the receiver stalls; the next
// request is still accepted and processed, and holds in its last step until
// the output register frees up.
// ----------------------------------------------------------------------------
module text_console_char_writer
    import tccw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [TAB_W-1:0]  cfg_wr_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        mode,
    input  logic [CHAR_W-1:0] char_code,
    input  logic [COL_W-1:0]  column,
    input  logic [ROW_W-1:0]  row,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CHAR_W-1:0] cell_char,
    output logic [ROW_W-1:0]  cursor_row,
    output logic [COL_W-1:0]  cursor_col,
    output logic              printed
);

    cmd_t    cmd;
    status_t status;

    assign in_ready = cmd.in_ready;

    // sequencer
    tccw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath and grid memory
    tccw_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .mode        (mode),
        .char_code   (char_code),
        .column      (column),
        .row         (row),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cell_char   (cell_char),
        .cursor_row  (cursor_row),
        .cursor_col  (cursor_col),
        .printed     (printed)
    );

endmodule

FILE: sv/tccw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tccw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/tccw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_ctrl
// Sequencer for the console: decodes each request, runs wrap checks, tab
// expansion, scroll and clear sweeps, and hands results to the output stage.
// ----------------------------------------------------------------------------
module tccw_ctrl
    import tccw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    // state and scroll return point
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT_CLR;
            ret_reg   <= S_FINISH;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        cmd           = '0;
        cmd.sweep_op  = SW_HOLD;
        cmd.waddr_sel = WA_SWEEP;
        cmd.wdata_sel = WD_SPACE;
        cmd.raddr_sel = RA_SWEEP;
        cmd.cur_op    = CUR_HOLD;
        cmd.tab_op    = TAB_HOLD;

        case (state_reg)
            // power-up blanking of the whole grid
            S_INIT_CLR:
            begin
                cmd.mem_we    = 1'b1;
                cmd.waddr_sel = WA_SWEEP;
                cmd.wdata_sel = WD_SPACE;
                if (status.sweep_end)
                begin
                    cmd.sweep_op = SW_ZERO;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.sweep_op = SW_INC;
                end
            end

            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                case (status.mode)
                    MODE_PRINT:
                    begin
                        // first wrap check
                        state_next = S_PCHAR;
                        if (status.at_wrap)
                        begin
                            if (status.at_bottom)
                            begin
                                cmd.sweep_op = SW_SCROLL;
                                ret_next     = S_PCHAR;
                                state_next   = S_SC_RD;
                            end
                            else
                            begin
                                cmd.cur_op = CUR_NEXT_ROW;
                            end
                        end
                    end
                    MODE_READ:
                    begin
                        cmd.raddr_sel = RA_INPUT;
                        state_next    = S_RD_CAP;
                    end
                    MODE_WRITE:
                    begin
                        cmd.mem_we    = status.addr_ok;
                        cmd.waddr_sel = WA_INPUT;
                        cmd.wdata_sel = WD_CHAR;
                        state_next    = S_FINISH;
                    end
                    default:
                    begin
                        cmd.sweep_op = SW_ZERO;
                        state_next   = S_CLR;
                    end
                endcase
            end

            // character dispatch after the wrap check
            S_PCHAR:
            begin
                state_next = S_FINISH;
                if (status.is_tab)
                begin
                    cmd.tab_op = TAB_LOAD;
                    state_next = S_TAB_CHK;
                end
                else if (status.is_bs)
                begin
                    if (!status.col_zero)
                    begin
                        cmd.mem_we    = 1'b1;
                        cmd.waddr_sel = WA_PREV;
                        cmd.wdata_sel = WD_SPACE;
                        cmd.cur_op    = CUR_DEC;
                    end
                end
                else if (status.is_nl)
                begin
                    if (status.at_bottom)
                    begin
                        cmd.sweep_op = SW_SCROLL;
                        ret_next     = S_FINISH;
                        state_next   = S_SC_RD;
                    end
                    else
                    begin
                        cmd.cur_op = CUR_NEXT_ROW;
                    end
                end
                else
                begin
                    cmd.mem_we      = 1'b1;
                    cmd.waddr_sel   = WA_CURSOR;
                    cmd.wdata_sel   = WD_CHAR;
                    cmd.cur_op      = CUR_INC;
                    cmd.set_printed = 1'b1;
                end
            end

            // per-space wrap check of a tab
            S_TAB_CHK:
            begin
                if (status.tab_zero)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_TAB_WR;
                    if (status.at_wrap)
                    begin
                        if (status.at_bottom)
                        begin
                            cmd.sweep_op = SW_SCROLL;
                            ret_next     = S_TAB_WR;
                            state_next   = S_SC_RD;
                        end
                        else
                        begin
                            cmd.cur_op = CUR_NEXT_ROW;
                        end
                    end
                end
            end

            S_TAB_WR:
            begin
                cmd.mem_we    = 1'b1;
                cmd.waddr_sel = WA_CURSOR;
                cmd.wdata_sel = WD_SPACE;
                cmd.cur_op    = CUR_INC;
                cmd.tab_op    = TAB_DEC;
                state_next    = S_TAB_CHK;
            end

            // scroll: fetch the cell one row below
            S_SC_RD:
            begin
                cmd.raddr_sel = RA_SWEEP;
                state_next    = S_SC_WR;
            end

            S_SC_WR:
            begin
                cmd.mem_we    = 1'b1;
                cmd.waddr_sel = WA_SWEEP;
                cmd.wdata_sel = WD_COPY;
                if (status.copy_end)
                begin
                    cmd.sweep_op = SW_BLANK;
                    state_next   = S_SC_BL;
                end
                else
                begin
                    cmd.sweep_op = SW_INC;
                    state_next   = S_SC_RD;
                end
            end

            // scroll: blank the bottom row
            S_SC_BL:
            begin
                cmd.mem_we    = 1'b1;
                cmd.waddr_sel = WA_SWEEP;
                cmd.wdata_sel = WD_SPACE;
                if (status.sweep_end)
                begin
                    cmd.cur_op = CUR_COL0;
                    state_next = ret_reg;
                end
                else
                begin
                    cmd.sweep_op = SW_INC;
                end
            end

            S_RD_CAP:
            begin
                cmd.cell_cap = status.addr_ok;
                state_next   = S_FINISH;
            end

            S_CLR:
            begin
                cmd.mem_we    = 1'b1;
                cmd.waddr_sel = WA_SWEEP;
                cmd.wdata_sel = WD_SPACE;
                if (status.sweep_end)
                begin
                    cmd.cur_op = CUR_HOME;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.sweep_op = SW_INC;
                end
            end

            // hand the result to the output register
            S_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/tccw_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_dp
// Console datapath: request capture, cursor, tab counter, sweep address,
// character grid memory and the output register.
// ----------------------------------------------------------------------------
module tccw_dp
    import tccw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output status_t           status,
    input  logic              cfg_wr_en,
    input  logic [TAB_W-1:0]  cfg_wr_data,
    input  logic              in_valid,
    input  logic [1:0]        mode,
    input  logic [CHAR_W-1:0] char_code,
    input  logic [COL_W-1:0]  column,
    input  logic [ROW_W-1:0]  row,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CHAR_W-1:0] cell_char,
    output logic [ROW_W-1:0]  cursor_row,
    output logic [COL_W-1:0]  cursor_col,
    output logic              printed
);

    localparam logic [ADDR_W-1:0] SCROLL_START = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] BLANK_START  = ADDR_W'((ROWS - 1) * COLUMNS);
    localparam logic [ADDR_W-1:0] COPY_LAST    = ADDR_W'((ROWS - 1) * COLUMNS - 1);
    localparam logic [ADDR_W-1:0] CELL_LAST    = ADDR_W'(CELLS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST     = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  COL_LAST     = COL_W'(COLUMNS - 1);

    // linear cell address of a row and column
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        logic [31:0] full;
        full = 32'(r) * 32'(COLUMNS) + 32'(c);
        return full[ADDR_W-1:0];
    endfunction

    logic [TAB_W-1:0]  tab_width_reg;
    mode_t             mode_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [COL_W-1:0]  in_col_reg;
    logic [ROW_W-1:0]  in_row_reg;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [TAB_W-1:0]  tab_cnt_reg, tab_cnt_next;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    logic [CHAR_W-1:0] cell_reg;
    logic              printed_reg;
    logic              out_valid_reg;
    logic [CHAR_W-1:0] out_cell_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic              out_printed_reg;

    logic              capture;
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] in_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] waddr;
    logic [CHAR_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
    logic [CHAR_W-1:0] rdata;

    assign capture  = cmd.in_ready && in_valid;
    assign cur_addr = cell_addr(cur_row_reg, cur_col_reg);
    assign in_addr  = cell_addr(in_row_reg, in_col_reg);

    // tab width register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tab_width_reg <= TAB_RESET;
        end
        else if (cfg_wr_en)
        begin
            tab_width_reg <= cfg_wr_data;
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            mode_reg   <= mode_t'(mode);
            char_reg   <= char_code;
            in_col_reg <= column;
            in_row_reg <= row;
        end
    end

    // cursor update
    always_comb
    begin
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        case (cmd.cur_op)
            CUR_HOME:
            begin
                cur_row_next = ROW_W'(1);
                cur_col_next = '0;
            end
            CUR_NEXT_ROW:
            begin
                cur_row_next = cur_row_reg + ROW_W'(1);
                cur_col_next = '0;
            end
            CUR_COL0:
            begin
                cur_col_next = '0;
            end
            CUR_INC:
            begin
                if (cur_col_reg < COL_LAST)
                begin
                    cur_col_next = cur_col_reg + COL_W'(1);
                end
            end
            CUR_DEC:
            begin
                cur_col_next = cur_col_reg - COL_W'(1);
            end
            default:
            begin
                cur_col_next = cur_col_reg;
            end
        endcase
    end

    // tab counter and sweep address
    always_comb
    begin
        case (cmd.tab_op)
            TAB_LOAD: tab_cnt_next = tab_width_reg;
            TAB_DEC:  tab_cnt_next = tab_cnt_reg - TAB_W'(1);
            default:  tab_cnt_next = tab_cnt_reg;
        endcase
        case (cmd.sweep_op)
            SW_ZERO:   sweep_next = '0;
            SW_SCROLL: sweep_next = SCROLL_START;
            SW_BLANK:  sweep_next = BLANK_START;
            SW_INC:    sweep_next = sweep_reg + ADDR_W'(1);
            default:   sweep_next = sweep_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg <= ROW_W'(1);
            cur_col_reg <= '0;
            sweep_reg   <= '0;
        end
        else
        begin
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            sweep_reg   <= sweep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tab_cnt_reg <= tab_cnt_next;
    end

    // per-request result flags
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            cell_reg    <= '0;
            printed_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cell_cap)
            begin
                cell_reg <= rdata;
            end
            if (cmd.set_printed)
            begin
                printed_reg <= 1'b1;
            end
        end
    end

    // memory port selection
    always_comb
    begin
        mem_we = cmd.mem_we;
        case (cmd.waddr_sel)
            WA_CURSOR: waddr = cur_addr;
            WA_PREV:   waddr = cur_addr - ADDR_W'(1);
            WA_INPUT:  waddr = in_addr;
            default:   waddr = sweep_reg;
        endcase
        case (cmd.wdata_sel)
            WD_CHAR: wdata = char_reg;
            WD_COPY: wdata = rdata;
            default: wdata = CH_SPACE;
        endcase
        case (cmd.raddr_sel)
            RA_INPUT: raddr = in_addr;
            default:  raddr = sweep_reg + ADDR_W'(COLUMNS);
        endcase
    end

    tccw_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (mem_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_cell_reg    <= cell_reg;
            out_row_reg     <= cur_row_reg;
            out_col_reg     <= cur_col_reg;
            out_printed_reg <= printed_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cell_char  = out_cell_reg;
    assign cursor_row = out_row_reg;
    assign cursor_col = out_col_reg;
    assign printed    = out_printed_reg;

    // status to the controller
    always_comb
    begin
        status.mode      = mode_reg;
        status.is_tab    = (char_reg == CH_TAB);
        status.is_bs     = (char_reg == CH_BACK);
        status.is_nl     = (char_reg == CH_NEWLINE);
        status.at_wrap   = (cur_col_reg >= COL_LAST);
        status.at_bottom = (cur_row_reg >= ROW_LAST);
        status.col_zero  = (cur_col_reg == '0);
        status.tab_zero  = (tab_cnt_reg == '0);
        status.addr_ok   = (32'(in_row_reg) < 32'(ROWS)) && (32'(in_col_reg) < 32'(COLUMNS));
        status.copy_end  = (sweep_reg == COPY_LAST);
        status.sweep_end = (sweep_reg == CELL_LAST);
        status.out_busy  = out_valid_reg && !out_ready;
    end

endmodule
